/* src/pirt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pirt_pkg
// Shared types, sizes and node helpers for the painted interval run tracker.
// ----------------------------------------------------------------------------
package pirt_pkg;

	localparam int unsigned LEVELS    = 16;
	localparam int unsigned POSITIONS = 1 << LEVELS;
	localparam int unsigned NODES     = 2 * POSITIONS;
	localparam int unsigned ADDR_W    = LEVELS + 1;
	localparam int unsigned LVL_W     = $clog2(LEVELS + 1);

	typedef struct packed {
		logic        pend_v;
		logic        pend_c;
		logic [15:0] runs;
		logic [16:0] black;
		logic        lcol;
		logic        rcol;
	} node_t;

	localparam int unsigned NODE_W = $bits(node_t);

	typedef enum logic [13:0] {
		ST_CLR      = 14'b00000000000001,
		ST_IDLE     = 14'b00000000000010,
		ST_PUSH_CHK = 14'b00000000000100,
		ST_PUSH_LD  = 14'b00000000001000,
		ST_PUSH_WL  = 14'b00000000010000,
		ST_PUSH_WR  = 14'b00000000100000,
		ST_PUSH_WV  = 14'b00000001000000,
		ST_APL_L    = 14'b00000010000000,
		ST_APL_R    = 14'b00000100000000,
		ST_UPD_CHK  = 14'b00001000000000,
		ST_UPD_RD1  = 14'b00010000000000,
		ST_UPD_WR   = 14'b00100000000000,
		ST_ROOT_RD  = 14'b01000000000000,
		ST_OUT      = 14'b10000000000000
	} state_t;

	// whole node painted one colour, assignment left pending for the children
	function automatic node_t set_whole(input logic c, input logic [16:0] len);
		node_t n;
		n.pend_v = 1'b1;
		n.pend_c = c;
		n.runs   = {15'd0, c};
		n.black  = c ? len : 17'd0;
		n.lcol   = c;
		n.rcol   = c;
		return n;
	endfunction

	// merge two halves; runs join where left ends black and right starts black
	function automatic node_t combine(input node_t a, input node_t b);
		node_t n;
		n.pend_v = 1'b0;
		n.pend_c = 1'b0;
		n.runs   = a.runs + b.runs - {15'd0, a.rcol & b.lcol};
		n.black  = a.black + b.black;
		n.lcol   = a.lcol;
		n.rcol   = b.rcol;
		return n;
	endfunction

endpackage
`default_nettype wire

/* src/painted_interval_run_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// painted_interval_run_tracker
// Paints clipped ranges of a 65536-cell line and reports black runs and cells.
// ----------------------------------------------------------------------------
// Input stream s_*: one paint per transfer (start_req, span, color). Output
// stream m_*: one result per paint (run_count, black_total) for the whole line.
// The line is a lazy segment tree held in one single-port RAM of 131072 nodes,
// heap-indexed with the root at 1. A paint pushes pending colours down the two
// boundary paths, writes the covering nodes, recombines the boundary paths and
// reads the root, all through the one RAM port; a paint of span zero goes
// straight to the root read. One paint is worked at a time: s_tready is high
// only while idle.
// After reset the RAM is cleared, one node a cycle, and no paint is taken
// meanwhile. A result holds on m_tdata until m_tready; the next paint can be
// taken in the cycle after the result transfer completes.
// ----------------------------------------------------------------------------
module painted_interval_run_tracker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // start_req[15:0], span[32:16], color[33], zero
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata    // run_count[15:0], black_total[32:16], zero
);

	pirt_pkg::state_t state_q;
	logic [pirt_pkg::LVL_W-1:0]  lvl_q;
	logic                        side_q;
	logic [16:0]                 lv_q;
	logic [17:0]                 rv_q;
	logic [17:0]                 a_q;
	logic [17:0]                 b_q;
	logic                        color_q;
	logic [pirt_pkg::ADDR_W-1:0] clr_q;
	pirt_pkg::node_t             nd_q;
	pirt_pkg::node_t             ch_q;
	logic [15:0]                 runs_q;
	logic [16:0]                 black_q;
	logic                        root_ld_q;

	logic                        ram_we;
	logic [pirt_pkg::ADDR_W-1:0] ram_addr;
	pirt_pkg::node_t             ram_wdata;
	pirt_pkg::node_t             ram_rdata;
	logic [pirt_pkg::NODE_W-1:0] ram_rraw;

	logic [17:0] mask;
	logic [17:0] node_full;
	logic [16:0] node;
	logic        cond;
	logic [16:0] len_child;
	logic [16:0] len_lvl;
	logic [17:0] b_dec;

	logic [15:0] in_start;
	logic [16:0] in_span;
	logic [15:0] lo;
	logic [17:0] hi_raw;
	logic [17:0] hi;

	assign in_start = s_tdata[15:0];
	assign in_span  = s_tdata[32:16];
	assign lo       = {~in_start[15], in_start[14:0]};
	assign hi_raw   = {2'b00, lo} + {1'b0, in_span};
	assign hi       = (hi_raw > 18'(pirt_pkg::POSITIONS)) ? 18'(pirt_pkg::POSITIONS) : hi_raw;

	assign mask      = (18'd1 << lvl_q) - 18'd1;
	assign node_full = side_q ? ((rv_q - 18'd1) >> lvl_q) : ({1'b0, lv_q} >> lvl_q);
	assign node      = node_full[16:0];
	assign cond      = side_q ? |(rv_q & mask) : |({1'b0, lv_q} & mask);
	assign len_child = 17'd1 << (lvl_q - pirt_pkg::LVL_W'(1));
	assign len_lvl   = 17'd1 << lvl_q;
	assign b_dec     = b_q - 18'd1;

	assign ram_rdata = pirt_pkg::node_t'(ram_rraw);

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = node;
		ram_wdata = '0;
		unique case (state_q)
			pirt_pkg::ST_CLR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			pirt_pkg::ST_PUSH_WL: begin
				ram_we    = 1'b1;
				ram_addr  = {node[15:0], 1'b0};
				ram_wdata = pirt_pkg::set_whole(nd_q.pend_c, len_child);
			end
			pirt_pkg::ST_PUSH_WR: begin
				ram_we    = 1'b1;
				ram_addr  = {node[15:0], 1'b1};
				ram_wdata = pirt_pkg::set_whole(nd_q.pend_c, len_child);
			end
			pirt_pkg::ST_PUSH_WV: begin
				ram_we           = 1'b1;
				ram_wdata        = nd_q;
				ram_wdata.pend_v = 1'b0;
			end
			pirt_pkg::ST_APL_L: begin
				ram_we    = (a_q < b_q) && a_q[0];
				ram_addr  = a_q[16:0];
				ram_wdata = pirt_pkg::set_whole(color_q, len_lvl);
			end
			pirt_pkg::ST_APL_R: begin
				ram_we    = b_q[0];
				ram_addr  = b_dec[16:0];
				ram_wdata = pirt_pkg::set_whole(color_q, len_lvl);
			end
			pirt_pkg::ST_UPD_CHK: ram_addr = {node[15:0], 1'b0};
			pirt_pkg::ST_UPD_RD1: ram_addr = {node[15:0], 1'b1};
			pirt_pkg::ST_UPD_WR: begin
				ram_we    = 1'b1;
				ram_wdata = pirt_pkg::combine(ch_q, ram_rdata);
			end
			pirt_pkg::ST_ROOT_RD: ram_addr = pirt_pkg::ADDR_W'(1);
			default: ;
		endcase
	end

	pirt_ram #(
		.WIDTH(pirt_pkg::NODE_W),
		.DEPTH(pirt_pkg::NODES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rraw)
	);

	// hold off m_tvalid while the root is still being captured
	assign s_tready = (state_q == pirt_pkg::ST_IDLE);
	assign m_tvalid = (state_q == pirt_pkg::ST_OUT) && !root_ld_q;
	assign m_tdata  = {7'd0, black_q, runs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pirt_pkg::ST_CLR;
			clr_q   <= '0;
			lvl_q   <= '0;
			side_q  <= 1'b0;
		end else begin
			unique case (state_q)
				pirt_pkg::ST_CLR: begin
					clr_q <= clr_q + pirt_pkg::ADDR_W'(1);
					if (&clr_q) begin
						state_q <= pirt_pkg::ST_IDLE;
					end
				end
				pirt_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						color_q <= s_tdata[33];
						lv_q    <= {1'b1, lo};
						rv_q    <= hi + 18'(pirt_pkg::POSITIONS);
						lvl_q   <= pirt_pkg::LVL_W'(pirt_pkg::LEVELS);
						side_q  <= 1'b0;
						state_q <= (in_span == 17'd0) ? pirt_pkg::ST_ROOT_RD
							: pirt_pkg::ST_PUSH_CHK;
					end
				end
				pirt_pkg::ST_PUSH_CHK, pirt_pkg::ST_PUSH_LD, pirt_pkg::ST_PUSH_WV: begin
					if (state_q == pirt_pkg::ST_PUSH_CHK && cond) begin
						state_q <= pirt_pkg::ST_PUSH_LD;
					end else if (state_q == pirt_pkg::ST_PUSH_LD && ram_rdata.pend_v) begin
						nd_q    <= ram_rdata;
						state_q <= pirt_pkg::ST_PUSH_WL;
					end else if (!side_q) begin
						side_q  <= 1'b1;
						state_q <= pirt_pkg::ST_PUSH_CHK;
					end else if (lvl_q == pirt_pkg::LVL_W'(1)) begin
						// boundary paths clean: paint the covering nodes
						side_q  <= 1'b0;
						lvl_q   <= '0;
						a_q     <= {1'b0, lv_q};
						b_q     <= rv_q;
						state_q <= pirt_pkg::ST_APL_L;
					end else begin
						side_q  <= 1'b0;
						lvl_q   <= lvl_q - pirt_pkg::LVL_W'(1);
						state_q <= pirt_pkg::ST_PUSH_CHK;
					end
				end
				pirt_pkg::ST_PUSH_WL: state_q <= pirt_pkg::ST_PUSH_WR;
				pirt_pkg::ST_PUSH_WR: state_q <= pirt_pkg::ST_PUSH_WV;
				pirt_pkg::ST_APL_L: begin
					if (a_q >= b_q) begin
						lvl_q   <= pirt_pkg::LVL_W'(1);
						side_q  <= 1'b0;
						state_q <= pirt_pkg::ST_UPD_CHK;
					end else begin
						if (a_q[0]) begin
							a_q <= a_q + 18'd1;
						end
						state_q <= pirt_pkg::ST_APL_R;
					end
				end
				pirt_pkg::ST_APL_R: begin
					a_q     <= a_q >> 1;
					b_q     <= (b_q[0] ? b_dec : b_q) >> 1;
					lvl_q   <= lvl_q + pirt_pkg::LVL_W'(1);
					state_q <= pirt_pkg::ST_APL_L;
				end
				pirt_pkg::ST_UPD_CHK, pirt_pkg::ST_UPD_WR: begin
					if (state_q == pirt_pkg::ST_UPD_CHK && cond) begin
						state_q <= pirt_pkg::ST_UPD_RD1;
					end else if (!side_q) begin
						side_q  <= 1'b1;
						state_q <= pirt_pkg::ST_UPD_CHK;
					end else if (lvl_q == pirt_pkg::LVL_W'(pirt_pkg::LEVELS)) begin
						side_q  <= 1'b0;
						state_q <= pirt_pkg::ST_ROOT_RD;
					end else begin
						side_q  <= 1'b0;
						lvl_q   <= lvl_q + pirt_pkg::LVL_W'(1);
						state_q <= pirt_pkg::ST_UPD_CHK;
					end
				end
				pirt_pkg::ST_UPD_RD1: begin
					ch_q    <= ram_rdata;
					state_q <= pirt_pkg::ST_UPD_WR;
				end
				pirt_pkg::ST_ROOT_RD: begin
					// issue the root read; the RAM's registered data arrives as ST_OUT begins
					state_q <= pirt_pkg::ST_OUT;
				end
				pirt_pkg::ST_OUT: begin
					if (m_tready && !root_ld_q) begin
						state_q <= pirt_pkg::ST_IDLE;
					end
				end
				default: state_q <= pirt_pkg::ST_IDLE;
			endcase
		end
	end

	// capture the root the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_ld_q <= 1'b0;
		end else begin
			root_ld_q <= (state_q == pirt_pkg::ST_ROOT_RD);
		end
	end

	always_ff @(posedge clk) begin
		if (root_ld_q) begin
			runs_q  <= ram_rdata.runs;
			black_q <= ram_rdata.black;
		end
	end

endmodule
`default_nettype wire

/* src/pirt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pirt_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module pirt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

/* tb/painted_interval_run_tracker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// painted_interval_run_tracker_tb
// Paints ranges onto the cell line and checks the black run count and the
// black cell total that come back. A cell-level copy of the line in the
// scoreboard predicts each result. Both stream sides idle at random, and the
// receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module painted_interval_run_tracker_tb;

	localparam int unsigned POSITIONS  = pirt_pkg::POSITIONS;
	localparam int unsigned HALF       = POSITIONS / 2;
	localparam int unsigned IDLE_LIMIT = 600000;
	localparam int unsigned N_RANDOM   = 600;

	typedef struct {
		logic [15:0] runs;
		logic [16:0] black;
	} line_counts_t;

	class line_scoreboard;
		bit           shade [0:POSITIONS-1];
		int unsigned  runs_now;
		int unsigned  black_now;
		line_counts_t counts_due [$];
		int           errors;
		int           checked;

		function new();
			foreach (shade[i]) shade[i] = 1'b0;
			runs_now  = 0;
			black_now = 0;
			errors    = 0;
			checked   = 0;
		endfunction

		// runs that begin within [a, b], judged from the cells at a-1 .. b
		function int unsigned starts_in(int a, int b);
			int unsigned n;
			n = 0;
			for (int i = a; i <= b; i++)
				if (shade[i] && (i == 0 || !shade[i-1])) n++;
			return n;
		endfunction

		// note an accepted paint and queue the counts it leaves behind
		function void note_paint(logic signed [15:0] start_req, logic [16:0] span,
				logic colour);
			int           lo, hi, top;
			int unsigned  old_starts;
			line_counts_t due;
			lo = int'(start_req) + HALF;
			hi = lo + int'(span);
			if (lo < 0) lo = 0;
			if (hi > POSITIONS) hi = POSITIONS;
			if (lo < hi) begin
				top = (hi < POSITIONS) ? hi : POSITIONS - 1;
				old_starts = starts_in(lo, top);
				for (int i = lo; i < hi; i++) begin
					black_now = black_now - shade[i] + colour;
					shade[i] = colour;
				end
				runs_now = runs_now - old_starts + starts_in(lo, top);
			end
			due.runs  = (runs_now > 16'hFFFF) ? 16'hFFFF : runs_now[15:0];
			due.black = (black_now > 17'h1FFFF) ? 17'h1FFFF : black_now[16:0];
			counts_due.push_back(due);
		endfunction

		task report(string what);
			errors++;
			$display("mismatch @%0t: %s", $realtime, what);
		endtask

		task check_result(logic [15:0] runs, logic [16:0] black);
			line_counts_t due;
			checked++;
			if (counts_due.size() == 0) begin
				report($sformatf("unexpected result runs=%0d black=%0d", runs, black));
			end else begin
				due = counts_due.pop_front();
				if (runs !== due.runs)
					report($sformatf("run_count %0d, want %0d", runs, due.runs));
				if (black !== due.black)
					report($sformatf("black_total %0d, want %0d", black, due.black));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // start_req[15:0], span[32:16], color[33], zero
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // run_count[15:0], black_total[32:16], zero

	line_scoreboard sb;
	int unsigned    paints_sent;
	int unsigned    idle_cycles;
	bit             hold_request;

	painted_interval_run_tracker uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 12) return 0;
		if (r < 18) return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	// offer one paint and hold it until the transfer
	task automatic send_paint(logic signed [15:0] start_req, logic [16:0] span,
			logic colour, int unsigned gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, colour, span, start_req};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		paints_sent++;
	endtask

	// random paint, mostly clustered near the middle so runs meet and split
	task automatic send_random(int unsigned gap);
		int unsigned       r;
		logic signed [15:0] st;
		logic [16:0]       sp;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			st = 16'(int'($urandom_range(0, 255)) - 128);
			sp = 17'($urandom_range(0, 40));
		end else if (r < 92) begin
			st = 16'($urandom);
			sp = 17'($urandom_range(0, 300));
		end else begin
			st = 16'($urandom);
			sp = 17'($urandom_range(0, 17'h1FFFF));
		end
		send_paint(st, sp, 1'($urandom_range(0, 1)), gap);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (4000) @(posedge clk);
			end
			if ($urandom_range(0, 29) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(20, 100)) @(posedge clk);
			end
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// both sides sampled on the edge, before the block updates
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_paint(s_tdata[15:0], s_tdata[32:16], s_tdata[33]);
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata[15:0], m_tdata[32:16]);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: %0d cycles without a transfer", idle_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		sb           = new();
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		paints_sent  = 0;
		idle_cycles  = 0;
		hold_request = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, zero span, clipping, whole line both colours
		send_paint(16'sh8000, 17'd0,     1'b1, 0);
		send_paint(16'sh8000, 17'd65536, 1'b1, 0);
		send_paint(16'sh0000, 17'd1,     1'b0, 0);
		send_paint(16'sh0002, 17'd1,     1'b0, 0);
		send_paint(16'sh0001, 17'd1,     1'b1, 0);
		send_paint(16'sh8000, 17'h1FFFF, 1'b0, 0);
		send_paint(16'sh7FFF, 17'd65536, 1'b1, 0);
		send_paint(16'sh7FFE, 17'd1,     1'b1, 0);
		send_paint(16'sh8000, 17'd1,     1'b1, 0);
		send_paint(16'sh8001, 17'd2,     1'b1, 0);
		send_paint(16'sh7FFF, 17'd0,     1'b0, 0);
		send_paint(-16'sd10,  17'd5,     1'b1, 0);
		send_paint(-16'sd4,   17'd3,     1'b1, 0);
		send_paint(-16'sd5,   17'd1,     1'b1, 0);
		send_paint(-16'sd8,   17'd2,     1'b0, 0);
		send_paint(16'sh5555, 17'h0AAAA, 1'b1, 0);
		send_paint(16'shAAAA, 17'h15555, 1'b0, 0);
		send_paint(16'sh8000, 17'd65535, 1'b0, 0);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) hold_request = 1'b1;
			send_random(pick_gap());
		end
		s_tvalid <= 1'b0;

		// wait for every result, then watch a while for strays
		while (sb.checked < paints_sent) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("sent %0d paints, checked %0d results", paints_sent, sb.checked);
		$display("covered zero spans, clipped edges, full-line paints, long stall");
		if (sb.errors == 0 && sb.counts_due.size() == 0 && sb.checked == paints_sent)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
